@@ hw/rtl/dps_pkg.sv @@
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and constants of the DNA pattern scanner: word layouts,
// operation codes, base characters and the node entry of the automaton.
// ----------------------------------------------------------------------------
`default_nettype none

package dps_pkg;

  localparam int unsigned NODE_COUNT_DEF    = 1024;
  localparam int unsigned POSITION_BITS_DEF = 32;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned NODE_W  = 10;
  localparam int unsigned PAT_W   = 8;
  localparam int unsigned DEPTH_W = 7;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned START_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_SCAN  = 2'd1,
    OP_START = 2'd2
  } op_e;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [NODE_W-1:0]  node_index;
    logic [NODE_W-1:0]  next_on_a;
    logic [NODE_W-1:0]  next_on_c;
    logic [NODE_W-1:0]  next_on_g;
    logic [NODE_W-1:0]  next_on_t;
    logic               is_terminal;
    logic [PAT_W-1:0]   pattern_number;
    logic [DEPTH_W-1:0] match_depth;
    logic [CHAR_W-1:0]  base_char;
  } scan_in_t;

  typedef struct packed {
    logic               hit;
    logic [PAT_W-1:0]   hit_pattern;
    logic [START_W-1:0] hit_start;
  } scan_out_t;

  typedef struct packed {
    logic [NODE_W-1:0]  next_a;
    logic [NODE_W-1:0]  next_c;
    logic [NODE_W-1:0]  next_g;
    logic [NODE_W-1:0]  next_t;
    logic               term;
    logic [PAT_W-1:0]   pattern;
    logic [DEPTH_W-1:0] depth;
  } node_t;

  typedef struct packed {
    logic wr;
    logic rd;
    logic fwd;
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/dps_node_mem.sv @@
// ----------------------------------------------------------------------------
// dps_node_mem
// Node memory of the automaton: one write port, one read port with a
// registered read word that also takes a load aimed at the current node.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_node_mem
  import dps_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF,
  parameter int unsigned AW         = $clog2(NODE_COUNT)
) (
  input  wire logic          clk_i,
  input  wire mem_ctl_t      ctl_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire node_t         wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output node_t              rdata_o
);

  node_t mem_q [NODE_COUNT];
  node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read word holds the current node; a load to that node refreshes it
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rdata_q <= mem_q[raddr_i];
    end else if (ctl_i.fwd) begin
      rdata_q <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/dps_step.sv @@
// ----------------------------------------------------------------------------
// dps_step
// Input stage: decodes each accepted word, picks the successor node from
// the current node entry, drives the node memory and keeps the position.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_step
  import dps_pkg::*;
#(
  parameter int unsigned NODE_COUNT    = NODE_COUNT_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned AW            = $clog2(NODE_COUNT)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_fire_i,
  input  wire scan_in_t                 in_data_i,
  input  wire node_t                    node_i,
  output mem_ctl_t                      mem_ctl_o,
  output logic [AW-1:0]                 waddr_o,
  output node_t                         wdata_o,
  output logic [AW-1:0]                 raddr_o,
  output logic                          scan_o,
  output logic [POSITION_BITS-1:0]      pos_o
);

  logic [AW-1:0]            cur_q, cur_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [NODE_W-1:0]        nxt_raw;
  logic [NODE_W-1:0]        nxt;
  logic                     is_load, is_scan, is_start, load_ok;

  always_comb begin
    is_load  = 1'b0;
    is_scan  = 1'b0;
    is_start = 1'b0;
    case (in_data_i.operation)
      OP_LOAD:  is_load  = in_fire_i;
      OP_SCAN:  is_scan  = in_fire_i;
      OP_START: is_start = in_fire_i;
      default: ;
    endcase
  end

  assign load_ok = is_load && (int'(in_data_i.node_index) < NODE_COUNT);

  always_comb begin
    case (in_data_i.base_char)
      CHAR_A:  nxt_raw = node_i.next_a;
      CHAR_C:  nxt_raw = node_i.next_c;
      CHAR_G:  nxt_raw = node_i.next_g;
      CHAR_T:  nxt_raw = node_i.next_t;
      default: nxt_raw = '0;
    endcase
    // successor outside the table goes to the root
    nxt = (int'(nxt_raw) < NODE_COUNT) ? nxt_raw : '0;
  end

  always_comb begin
    cur_d = cur_q;
    pos_d = pos_q;
    if (is_scan) begin
      cur_d = AW'(nxt);
      if (pos_q != '1) begin
        pos_d = pos_q + POSITION_BITS'(1);
      end
    end else if (is_start) begin
      cur_d = '0;
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      pos_q <= '0;
    end else begin
      cur_q <= cur_d;
      pos_q <= pos_d;
    end
  end

  assign mem_ctl_o.wr  = load_ok;
  assign mem_ctl_o.rd  = is_scan || is_start;
  assign mem_ctl_o.fwd = load_ok && (AW'(in_data_i.node_index) == cur_q);

  assign waddr_o = AW'(in_data_i.node_index);
  assign raddr_o = is_scan ? AW'(nxt) : '0;

  assign wdata_o.next_a  = in_data_i.next_on_a;
  assign wdata_o.next_c  = in_data_i.next_on_c;
  assign wdata_o.next_g  = in_data_i.next_on_g;
  assign wdata_o.next_t  = in_data_i.next_on_t;
  assign wdata_o.term    = in_data_i.is_terminal;
  assign wdata_o.pattern = in_data_i.pattern_number;
  assign wdata_o.depth   = in_data_i.match_depth;

  assign scan_o = is_scan;
  assign pos_o  = pos_q;

endmodule

`default_nettype wire

@@ hw/rtl/dps_result.sv @@
// ----------------------------------------------------------------------------
// dps_result
// Result stage: forms hit, pattern and start position from the node just
// reached and holds the result word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_result
  import dps_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     scan_i,
  input  wire logic [POSITION_BITS-1:0] pos_i,
  input  wire node_t                    node_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output scan_out_t                     out_data_o
);

  localparam int unsigned PW1 = POSITION_BITS + 1;

  logic                     pend_q, pend_d;
  logic [POSITION_BITS-1:0] pos_q;
  logic                     out_valid_q;
  scan_out_t                out_data_q, res;
  logic                     adv;
  logic [PW1-1:0]           pos_p1, dep, start_full;

  assign adv    = !out_valid_q || out_ready_i;
  assign free_o = !pend_q || adv;

  always_comb begin
    pos_p1     = {1'b0, pos_q} + PW1'(1);
    dep        = PW1'(node_i.depth);
    // depth beyond position plus one clamps to zero
    start_full = (dep > pos_p1) ? '0 : (pos_p1 - dep);
    res        = '0;
    if (node_i.term) begin
      res.hit         = 1'b1;
      res.hit_pattern = node_i.pattern;
      res.hit_start   = START_W'(start_full);
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (scan_i) begin
      pend_d = 1'b1;
    end else if (adv) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (adv) begin
        out_valid_q <= pend_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_i) begin
      pos_q <= pos_i;
    end
    if (adv && pend_q) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/dna_pattern_scan.sv @@
// ----------------------------------------------------------------------------
// dna_pattern_scan
// Streams DNA characters through a preloaded Aho-Corasick automaton and
// reports pattern hits with pattern id and start position.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while input ready is high, loads, starts
// and scans alike; a scan word's result passes the node memory's read
// register and then the output register, and other words give none. The
// rate is set by the next-node loop: the current node entry sits in the
// node memory's read register, the successor is picked from it by the
// character and addressed back into the memory in the same cycle. The node
// memory is not cleared after reset; the root and every node that a scan
// can reach must be loaded before scanning. Input ready drops only while a
// result waits in the output register with a second one behind it.
`default_nettype none

module dna_pattern_scan
  import dps_pkg::*;
#(
  parameter int unsigned NODE_COUNT    = NODE_COUNT_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire scan_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output scan_out_t      out_data_o
);

  localparam int unsigned AW = $clog2(NODE_COUNT);

  mem_ctl_t                 mem_ctl;
  logic [AW-1:0]            waddr, raddr;
  node_t                    wdata, node;
  logic                     scan;
  logic [POSITION_BITS-1:0] pos;
  logic                     free;
  logic                     in_fire;

  assign in_ready_o = free;
  assign in_fire    = in_valid_i && free;

  dps_step #(
    .NODE_COUNT    (NODE_COUNT),
    .POSITION_BITS (POSITION_BITS),
    .AW            (AW)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_data_i (in_data_i),
    .node_i    (node),
    .mem_ctl_o (mem_ctl),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .raddr_o   (raddr),
    .scan_o    (scan),
    .pos_o     (pos)
  );

  dps_node_mem #(
    .NODE_COUNT (NODE_COUNT),
    .AW         (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (node)
  );

  dps_result #(
    .POSITION_BITS (POSITION_BITS)
  ) u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_i      (scan),
    .pos_i       (pos),
    .node_i      (node),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/dps_checker.sv @@
// ----------------------------------------------------------------------------
// dps_checker
// Port-level checks of the DNA pattern scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_checker
  import dps_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire scan_in_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire scan_out_t out_data_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // a miss carries no pattern and no start
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.hit_pattern == '0 &&
    out_data_o.hit_start == '0)
    else $error("miss word with nonzero fields");

  // input stalls only behind a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a scan word yields a result once the output register advances after the node read
  a_scan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.operation == OP_SCAN) ##1
    (!out_valid_o || out_ready_i) |=> out_valid_o)
    else $error("scan word gave no result");

endmodule

bind dna_pattern_scan dps_checker u_checker (.*);

`default_nettype wire
